/* rtl/core/srsmf_pkg.sv */
// Shared types and constants for the stereo router with smoothed gain matrix
// and mono fill. No dependencies; used by every module under rtl/core.
`default_nettype none

package srsmf_pkg;

    localparam int BLOCK_LEN   = 64;
    localparam int SAMPLE_BITS = 24;
    localparam int ADDR_BITS   = $clog2(BLOCK_LEN);
    localparam int W_BITS      = 32;
    localparam int PROD_BITS   = SAMPLE_BITS + W_BITS;
    localparam int RAMP_BITS   = 16;
    localparam int TH_BITS     = SAMPLE_BITS - 1;
    localparam int LANES       = 4;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [W_BITS-1:0]      weight_t;
    typedef logic signed [W_BITS:0]        dvd_t;
    typedef logic signed [PROD_BITS-1:0]   prod_t;
    typedef logic [TH_BITS-1:0]            mag_t;
    typedef logic [ADDR_BITS-1:0]          addr_t;
    typedef logic [RAMP_BITS-1:0]          ramp_t;

    localparam weight_t Q_ONE      = weight_t'(32'sh4000_0000);
    localparam ramp_t   RAMP_RESET = ramp_t'(2400);
    localparam mag_t    TH_RESET   = mag_t'(84);
    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam addr_t   LAST_ADDR  = addr_t'(BLOCK_LEN - 1);

    typedef enum logic [1:0] {
        REG_LEFT_EN    = 2'd0,
        REG_RIGHT_EN   = 2'd1,
        REG_RAMP_STEPS = 2'd2,
        REG_SILENCE_TH = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_COLLECT = 2'b01,
        ST_EMIT    = 2'b10
    } state_t;

    typedef enum logic [1:0] {
        FILL_NONE        = 2'd0,
        FILL_LEFT_FROM_R = 2'd1,
        FILL_RIGHT_FROM_L = 2'd2
    } fill_t;

    typedef struct packed {
        logic  valid;
        logic  last;
        fill_t fill;
    } lane_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/srsmf_buf.sv */
// Sample buffer: one synchronous memory holding left/right pairs of a block.
// Registered read port; data follows the read in the next cycle. Depends on srsmf_pkg.
`default_nettype none

module srsmf_buf (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  srsmf_pkg::addr_t      wr_addr,
    input  srsmf_pkg::sample_t    wr_left,
    input  srsmf_pkg::sample_t    wr_right,
    input  wire logic             rd_en,
    input  srsmf_pkg::addr_t      rd_addr,
    output srsmf_pkg::sample_t    rd_left,
    output srsmf_pkg::sample_t    rd_right
);

    localparam int DW = 2 * srsmf_pkg::SAMPLE_BITS;

    logic [DW-1:0] mem [srsmf_pkg::BLOCK_LEN];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_left, wr_right};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_left  = rd_data_reg[DW-1:srsmf_pkg::SAMPLE_BITS];
    assign rd_right = rd_data_reg[srsmf_pkg::SAMPLE_BITS-1:0];

endmodule

`default_nettype wire

/* rtl/core/srsmf_div.sv */
// Four-lane restoring divider for ramp step sizes, one quotient bit per cycle.
// Signed dividend over unsigned ramp length, truncated toward zero. Uses srsmf_pkg.
`default_nettype none

module srsmf_div (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  srsmf_pkg::ramp_t      divisor,
    input  srsmf_pkg::dvd_t       dividend [srsmf_pkg::LANES],
    output logic                  busy,
    output logic                  done,
    output srsmf_pkg::weight_t    quotient [srsmf_pkg::LANES]
);

    localparam int WB = srsmf_pkg::W_BITS;
    localparam int RB = srsmf_pkg::RAMP_BITS;
    localparam int CB = $clog2(WB);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CB-1:0]         cnt_reg;
    srsmf_pkg::ramp_t      divisor_reg;
    logic                  neg_reg  [srsmf_pkg::LANES];
    logic [WB-1:0]         work_reg [srsmf_pkg::LANES];
    logic [RB-1:0]         rem_reg  [srsmf_pkg::LANES];

    logic                  neg_next  [srsmf_pkg::LANES];
    logic [WB-1:0]         mag_next  [srsmf_pkg::LANES];
    logic [WB-1:0]         work_next [srsmf_pkg::LANES];
    logic [RB-1:0]         rem_next  [srsmf_pkg::LANES];

    always_comb
    begin
        logic [RB:0] rem_sh;
        logic [RB:0] diff;
        logic        ge;
        srsmf_pkg::dvd_t negd;
        for (int i = 0; i < srsmf_pkg::LANES; i++)
        begin
            neg_next[i] = dividend[i][WB];
            negd        = -dividend[i];
            mag_next[i] = neg_next[i] ? negd[WB-1:0] : dividend[i][WB-1:0];
            rem_sh      = {rem_reg[i], work_reg[i][WB-1]};
            diff        = rem_sh - {1'b0, divisor_reg};
            ge          = (rem_sh >= {1'b0, divisor_reg});
            rem_next[i] = ge ? diff[RB-1:0] : rem_sh[RB-1:0];
            work_next[i] = {work_reg[i][WB-2:0], ge};
            quotient[i] = neg_reg[i] ? -work_reg[i] : work_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CB'(WB - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            divisor_reg <= divisor;
            for (int i = 0; i < srsmf_pkg::LANES; i++)
            begin
                neg_reg[i]  <= neg_next[i];
                work_reg[i] <= mag_next[i];
                rem_reg[i]  <= '0;
            end
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < srsmf_pkg::LANES; i++)
            begin
                work_reg[i] <= work_next[i];
                rem_reg[i]  <= rem_next[i];
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

/* rtl/core/srsmf_mix.sv */
// Gain matrix datapath: mono fill select, four products, rounded sums with
// saturation, and the output register. Uses srsmf_pkg.
`default_nettype none

module srsmf_mix (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  srsmf_pkg::lane_ctl_t   issue_ctl,
    input  srsmf_pkg::sample_t     rd_left,
    input  srsmf_pkg::sample_t     rd_right,
    input  srsmf_pkg::weight_t     weight [srsmf_pkg::LANES],
    output logic                   adv,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output srsmf_pkg::sample_t     left_out,
    output srsmf_pkg::sample_t     right_out,
    output logic                   last_out
);

    localparam int PB = srsmf_pkg::PROD_BITS;
    localparam int SB = srsmf_pkg::SAMPLE_BITS;
    localparam int QB = PB + 1 - 30;
    localparam logic signed [PB:0] RND = (PB + 1)'(64'sd536870912);

    srsmf_pkg::lane_ctl_t s1_ctl_reg;
    srsmf_pkg::lane_ctl_t s2_ctl_reg;
    srsmf_pkg::prod_t     prod_reg [srsmf_pkg::LANES];
    logic                 out_valid_reg;
    logic                 last_reg;
    srsmf_pkg::sample_t   left_reg;
    srsmf_pkg::sample_t   right_reg;

    srsmf_pkg::sample_t   a_sel;
    srsmf_pkg::sample_t   b_sel;
    srsmf_pkg::sample_t   left_next;
    srsmf_pkg::sample_t   right_next;

    function automatic srsmf_pkg::sample_t round_sat(srsmf_pkg::prod_t p0,
                                                      srsmf_pkg::prod_t p1);
        logic signed [PB:0]   s;
        logic signed [QB-1:0] q;
        s = (PB + 1)'(p0) + (PB + 1)'(p1) + RND;
        q = s[PB:30];
        if (q[QB-1:SB-1] == {(QB-SB+1){q[SB-1]}})
            return q[SB-1:0];
        else
            return q[QB-1] ? srsmf_pkg::SAMPLE_MIN : srsmf_pkg::SAMPLE_MAX;
    endfunction

    assign adv = !out_valid_reg || !out_stall;

    always_comb
    begin
        a_sel = rd_left;
        b_sel = rd_right;
        case (s1_ctl_reg.fill)
            srsmf_pkg::FILL_LEFT_FROM_R:  a_sel = rd_right;
            srsmf_pkg::FILL_RIGHT_FROM_L: b_sel = rd_left;
            default: ;
        endcase
        left_next  = round_sat(prod_reg[0], prod_reg[1]);
        right_next = round_sat(prod_reg[2], prod_reg[3]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg    <= '0;
            s2_ctl_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_ctl_reg    <= issue_ctl;
            s2_ctl_reg    <= s1_ctl_reg;
            out_valid_reg <= s2_ctl_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg[0] <= a_sel * weight[0];
            prod_reg[1] <= b_sel * weight[1];
            prod_reg[2] <= a_sel * weight[2];
            prod_reg[3] <= b_sel * weight[3];
            left_reg    <= left_next;
            right_reg   <= right_next;
            last_reg    <= s2_ctl_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign left_out  = left_reg;
    assign right_out = right_reg;
    assign last_out  = last_reg;

endmodule

`default_nettype wire

/* rtl/core/stereo_router_smoothed_mono_fill_top.sv */
// Stereo router top level: config registers, peak tracking, block sequencing
// and weight ramp. Instantiates srsmf_buf, srsmf_div and srsmf_mix; uses srsmf_pkg.
//
// Input channel (in_valid/in_stall, left_in, right_in, block_end) takes one
// sample pair per cycle into the block buffer while collecting and in_stall
// is low. A transfer with block_end set, or the 64th transfer, closes the
// block; in_stall then rises and the buffered pairs are read back one per
// cycle unless out_stall holds them, run through the gain matrix and leave on
// the output channel (out_valid/out_stall, left_out, right_out, last_out),
// last_out marking the final pair. Each pair passes the buffer read, product
// and output registers. No new block is taken during read-back; collection
// resumes while the last results drain. out_stall freezes the read pipeline
// and the ramp. After reset and after each config write (APB, registers at
// 0x0/0x4/0x8/0xC) the divider computes the step sizes unless the ramp length
// is zero; in_stall is high while it is busy or signals done. Reset restores
// the register defaults and a ramp from zero.
`default_nettype none

module stereo_router_smoothed_mono_fill_top (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [3:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  srsmf_pkg::sample_t    left_in,
    input  srsmf_pkg::sample_t    right_in,
    input  wire logic             block_end,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output srsmf_pkg::sample_t    left_out,
    output srsmf_pkg::sample_t    right_out,
    output logic                  last_out
);

    localparam int LN = srsmf_pkg::LANES;

    logic                  left_en_reg;
    logic                  right_en_reg;
    srsmf_pkg::ramp_t      ramp_steps_reg;
    srsmf_pkg::mag_t       th_reg;
    logic                  init_pending_reg;
    srsmf_pkg::state_t     state_reg;
    srsmf_pkg::addr_t      fill_count_reg;
    srsmf_pkg::addr_t      rd_addr_reg;
    srsmf_pkg::addr_t      last_addr_reg;
    srsmf_pkg::fill_t      fill_reg;
    srsmf_pkg::mag_t       peak_left_reg;
    srsmf_pkg::mag_t       peak_right_reg;
    srsmf_pkg::ramp_t      ramp_left_reg;
    srsmf_pkg::weight_t    weight_now_reg    [LN];
    srsmf_pkg::weight_t    weight_target_reg [LN];
    srsmf_pkg::weight_t    weight_step_reg   [LN];

    logic                  cfg_wr;
    srsmf_pkg::reg_idx_t   cfg_idx;
    logic                  start_req;
    logic                  left_en_next;
    logic                  right_en_next;
    srsmf_pkg::ramp_t      ramp_steps_next;
    srsmf_pkg::mag_t       th_next;
    srsmf_pkg::weight_t    target_next [LN];
    srsmf_pkg::dvd_t       dividend    [LN];
    srsmf_pkg::weight_t    quotient    [LN];
    logic                  div_busy;
    logic                  div_done;

    logic                  in_xfer;
    logic                  issue;
    logic                  adv;
    logic                  block_done;
    srsmf_pkg::mag_t       mag_left;
    srsmf_pkg::mag_t       mag_right;
    srsmf_pkg::mag_t       peak_left_next;
    srsmf_pkg::mag_t       peak_right_next;
    srsmf_pkg::fill_t      fill_next;
    srsmf_pkg::ramp_t      ramp_dec;
    srsmf_pkg::lane_ctl_t  issue_ctl;
    srsmf_pkg::sample_t    rd_left;
    srsmf_pkg::sample_t    rd_right;

    function automatic srsmf_pkg::mag_t magnitude(srsmf_pkg::sample_t x);
        srsmf_pkg::sample_t n;
        n = -x;
        if (!x[srsmf_pkg::SAMPLE_BITS-1])
            return x[srsmf_pkg::SAMPLE_BITS-2:0];
        else if (x == srsmf_pkg::SAMPLE_MIN)
            return '1;
        else
            return n[srsmf_pkg::SAMPLE_BITS-2:0];
    endfunction

    // config port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = srsmf_pkg::reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        unique case (cfg_idx)
            srsmf_pkg::REG_LEFT_EN:    prdata = {31'b0, left_en_reg};
            srsmf_pkg::REG_RIGHT_EN:   prdata = {31'b0, right_en_reg};
            srsmf_pkg::REG_RAMP_STEPS: prdata = {16'b0, ramp_steps_reg};
            srsmf_pkg::REG_SILENCE_TH: prdata = {9'b0, th_reg};
        endcase
    end

    always_comb
    begin
        left_en_next    = left_en_reg;
        right_en_next   = right_en_reg;
        ramp_steps_next = ramp_steps_reg;
        th_next         = th_reg;
        if (cfg_wr)
        begin
            unique case (cfg_idx)
                srsmf_pkg::REG_LEFT_EN:    left_en_next    = pwdata[0];
                srsmf_pkg::REG_RIGHT_EN:   right_en_next   = pwdata[0];
                srsmf_pkg::REG_RAMP_STEPS: ramp_steps_next = pwdata[15:0];
                srsmf_pkg::REG_SILENCE_TH: th_next         = pwdata[22:0];
            endcase
        end
        for (int i = 0; i < LN; i++)
        begin
            target_next[i] = '0;
        end
        if (left_en_next && right_en_next)
        begin
            target_next[0] = srsmf_pkg::Q_ONE;
            target_next[3] = srsmf_pkg::Q_ONE;
        end
        else if (left_en_next)
        begin
            target_next[0] = srsmf_pkg::Q_ONE;
            target_next[2] = srsmf_pkg::Q_ONE;
        end
        else if (right_en_next)
        begin
            target_next[1] = srsmf_pkg::Q_ONE;
            target_next[3] = srsmf_pkg::Q_ONE;
        end
        for (int i = 0; i < LN; i++)
        begin
            dividend[i] = (srsmf_pkg::W_BITS + 1)'(target_next[i])
                        - (srsmf_pkg::W_BITS + 1)'(weight_now_reg[i]);
        end
    end

    assign start_req = cfg_wr || init_pending_reg;

    // input side and block close
    assign in_stall = (state_reg != srsmf_pkg::ST_COLLECT) || init_pending_reg
                    || div_busy || div_done;
    assign in_xfer  = in_valid && !in_stall;
    assign issue    = (state_reg == srsmf_pkg::ST_EMIT) && adv;
    assign ramp_dec = ramp_left_reg - 1'b1;

    always_comb
    begin
        mag_left        = magnitude(left_in);
        mag_right       = magnitude(right_in);
        peak_left_next  = (mag_left > peak_left_reg) ? mag_left : peak_left_reg;
        peak_right_next = (mag_right > peak_right_reg) ? mag_right : peak_right_reg;
        block_done      = block_end || (fill_count_reg == srsmf_pkg::LAST_ADDR);
        fill_next       = srsmf_pkg::FILL_NONE;
        if (left_en_reg && right_en_reg)
        begin
            if (peak_right_next < th_reg && peak_left_next > th_reg)
                fill_next = srsmf_pkg::FILL_RIGHT_FROM_L;
            else if (peak_left_next < th_reg && peak_right_next > th_reg)
                fill_next = srsmf_pkg::FILL_LEFT_FROM_R;
        end
        issue_ctl.valid = issue;
        issue_ctl.last  = (rd_addr_reg == last_addr_reg);
        issue_ctl.fill  = fill_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_en_reg      <= 1'b1;
            right_en_reg     <= 1'b1;
            ramp_steps_reg   <= srsmf_pkg::RAMP_RESET;
            th_reg           <= srsmf_pkg::TH_RESET;
            init_pending_reg <= 1'b1;
            state_reg        <= srsmf_pkg::ST_COLLECT;
            fill_count_reg   <= '0;
            rd_addr_reg      <= '0;
            last_addr_reg    <= '0;
            fill_reg         <= srsmf_pkg::FILL_NONE;
            peak_left_reg    <= '0;
            peak_right_reg   <= '0;
            ramp_left_reg    <= srsmf_pkg::RAMP_RESET;
            for (int i = 0; i < LN; i++)
            begin
                weight_now_reg[i]    <= '0;
                weight_target_reg[i] <= '0;
                weight_step_reg[i]   <= '0;
            end
        end
        else
        begin
            if (start_req)
            begin
                left_en_reg      <= left_en_next;
                right_en_reg     <= right_en_next;
                ramp_steps_reg   <= ramp_steps_next;
                th_reg           <= th_next;
                init_pending_reg <= 1'b0;
                ramp_left_reg    <= ramp_steps_next;
                for (int i = 0; i < LN; i++)
                begin
                    weight_target_reg[i] <= target_next[i];
                    if (ramp_steps_next == '0)
                    begin
                        weight_now_reg[i]  <= target_next[i];
                        weight_step_reg[i] <= '0;
                    end
                end
            end
            else if (div_done)
            begin
                for (int i = 0; i < LN; i++)
                begin
                    weight_step_reg[i] <= quotient[i];
                end
            end

            if (issue && ramp_left_reg != '0)
            begin
                ramp_left_reg <= ramp_dec;
                for (int i = 0; i < LN; i++)
                begin
                    weight_now_reg[i] <= (ramp_dec != '0)
                                       ? weight_now_reg[i] + weight_step_reg[i]
                                       : weight_target_reg[i];
                end
            end

            unique case (state_reg)
                srsmf_pkg::ST_COLLECT:
                begin
                    if (in_xfer)
                    begin
                        if (block_done)
                        begin
                            state_reg      <= srsmf_pkg::ST_EMIT;
                            last_addr_reg  <= fill_count_reg;
                            rd_addr_reg    <= '0;
                            fill_reg       <= fill_next;
                            fill_count_reg <= '0;
                            peak_left_reg  <= '0;
                            peak_right_reg <= '0;
                        end
                        else
                        begin
                            fill_count_reg <= fill_count_reg + 1'b1;
                            peak_left_reg  <= peak_left_next;
                            peak_right_reg <= peak_right_next;
                        end
                    end
                end
                srsmf_pkg::ST_EMIT:
                begin
                    if (issue)
                    begin
                        rd_addr_reg <= rd_addr_reg + 1'b1;
                        if (rd_addr_reg == last_addr_reg)
                        begin
                            state_reg <= srsmf_pkg::ST_COLLECT;
                        end
                    end
                end
                default:
                begin
                    state_reg <= srsmf_pkg::ST_COLLECT;
                end
            endcase
        end
    end

    srsmf_buf u_buf (
        .clk      (clk),
        .wr_en    (in_xfer),
        .wr_addr  (fill_count_reg),
        .wr_left  (left_in),
        .wr_right (right_in),
        .rd_en    (issue),
        .rd_addr  (rd_addr_reg),
        .rd_left  (rd_left),
        .rd_right (rd_right)
    );

    srsmf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_req && (ramp_steps_next != '0)),
        .divisor  (ramp_steps_next),
        .dividend (dividend),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quotient)
    );

    srsmf_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue_ctl (issue_ctl),
        .rd_left   (rd_left),
        .rd_right  (rd_right),
        .weight    (weight_now_reg),
        .adv       (adv),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .left_out  (left_out),
        .right_out (right_out),
        .last_out  (last_out)
    );

endmodule

`default_nettype wire
